[rtl/gap_buffer_text_editor_assert.svh]
// Assertion macros for the gap buffer text editor.
`ifndef GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH
`define GAP_BUFFER_TEXT_EDITOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising edge out of reset.
`define GBTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a rising edge out of reset.
`define GBTE_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define GBTE_ASSERT(lbl, clk, rstn, prop, msg)
`define GBTE_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/gbte_pkg.sv]
// Shared constants and types of the gap buffer text editor.
`default_nettype none

package gbte_pkg;

    localparam int BUF_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = 13;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 12;
    localparam int REQ_W     = 3;

    // Largest usable length: the store depth, capped at what the length field holds.
    localparam logic [LEN_W-1:0] LEN_MAX   = (BUF_DEPTH > 8191) ? {LEN_W{1'b1}}
                                                                : LEN_W'(BUF_DEPTH);
    localparam logic [LEN_W-1:0] LEN_RESET = (BUF_DEPTH < 4096) ? LEN_W'(BUF_DEPTH)
                                                                : LEN_W'(4096);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT     = 3'd0,
        REQ_MOVE_LEFT  = 3'd1,
        REQ_MOVE_RIGHT = 3'd2,
        REQ_DELETE     = 3'd3,
        REQ_BACKSPACE  = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    // Length register as seen by the controller.
    typedef struct packed {
        logic             wr;
        logic [LEN_W-1:0] wr_len;
        logic [LEN_W-1:0] len;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  text_len;
        logic [LEN_W-1:0]  cursor;
        logic [LEN_W-1:0]  gap;
    } res_t;

    // Store access issued by the controller.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

[rtl/gbte_text_ram.sv]
// Character store: one write port, one read port, registered read data.
`default_nettype none

module gbte_text_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/gbte_ctrl.sv]
// Gap pointers, request decode and result register of the gap buffer.
`default_nettype none

module gbte_ctrl
    import gbte_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [REQ_W-1:0]  in_req,
    input  wire logic [CHAR_W-1:0] in_char,
    input  wire logic [IDX_W-1:0]  in_idx,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output res_t                   out_res,
    output ram_req_t               ram,
    input  wire logic [CHAR_W-1:0] ram_rdata
);

    typedef enum logic {
        ST_IDLE,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  gs_reg, gs_next;
    logic [LEN_W-1:0]  ga_reg, ga_next;
    logic              pend_ok_reg, pend_ok_next;
    logic              pend_rd_reg, pend_rd_next;
    logic              pend_wr_reg, pend_wr_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              accept;
    logic              ok;
    req_t              req;
    logic [LEN_W-1:0]  gap;
    logic [LEN_W-1:0]  text_len;
    logic [LEN_W-1:0]  phys;

    assign req      = req_t'(in_req);
    assign gap      = ga_reg - gs_reg;
    assign text_len = cfg.len - gap;
    assign phys     = ({1'b0, in_idx} < gs_reg) ? {1'b0, in_idx} : ({1'b0, in_idx} + gap);

    // Take a request only when the result register is free by the finish cycle.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb begin
        ok             = 1'b0;
        gs_next        = gs_reg;
        ga_next        = ga_reg;
        state_next     = state_reg;
        pend_ok_next   = pend_ok_reg;
        pend_rd_next   = pend_rd_reg;
        pend_wr_next   = pend_wr_reg;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram            = '0;

        unique case (req)
            REQ_INSERT:     ok = ga_reg > gs_reg;
            REQ_MOVE_LEFT:  ok = gs_reg != '0;
            REQ_MOVE_RIGHT: ok = ga_reg < cfg.len;
            REQ_DELETE:     ok = ga_reg < cfg.len;
            REQ_BACKSPACE:  ok = gs_reg != '0;
            REQ_READ:       ok = {1'b0, in_idx} < text_len;
            default:        ok = 1'b0;
        endcase

        if (state_reg == ST_IDLE) begin
            if (accept) begin
                state_next   = ST_FIN;
                pend_ok_next = ok;
                pend_rd_next = (req == REQ_READ) && ok;
                pend_wr_next = 1'b0;
                if (ok) begin
                    unique case (req)
                        REQ_INSERT: begin
                            ram.we    = 1'b1;
                            ram.waddr = ADDR_W'(gs_reg);
                            ram.wdata = in_char;
                            gs_next   = gs_reg + 1'b1;
                        end
                        REQ_MOVE_LEFT: begin
                            ram.re         = 1'b1;
                            ram.raddr      = ADDR_W'(gs_reg - 1'b1);
                            pend_wr_next   = 1'b1;
                            pend_addr_next = ADDR_W'(ga_reg - 1'b1);
                            gs_next        = gs_reg - 1'b1;
                            ga_next        = ga_reg - 1'b1;
                        end
                        REQ_MOVE_RIGHT: begin
                            ram.re         = 1'b1;
                            ram.raddr      = ADDR_W'(ga_reg);
                            pend_wr_next   = 1'b1;
                            pend_addr_next = ADDR_W'(gs_reg);
                            gs_next        = gs_reg + 1'b1;
                            ga_next        = ga_reg + 1'b1;
                        end
                        REQ_DELETE:    ga_next = ga_reg + 1'b1;
                        REQ_BACKSPACE: gs_next = gs_reg - 1'b1;
                        REQ_READ: begin
                            ram.re    = 1'b1;
                            ram.raddr = ADDR_W'(phys);
                        end
                        default: ;
                    endcase
                end
            end
        end else begin
            // Finish: write back a carried character and load the result.
            state_next = ST_IDLE;
            if (pend_wr_reg) begin
                ram.we    = 1'b1;
                ram.waddr = pend_addr_reg;
                ram.wdata = ram_rdata;
            end
            out_valid_next   = 1'b1;
            out_next.ok      = pend_ok_reg;
            out_next.ch      = pend_rd_reg ? ram_rdata : '0;
            out_next.text_len = text_len;
            out_next.cursor  = gs_reg;
            out_next.gap     = gap;
        end

        // Length write reopens the whole store as gap.
        if (cfg.wr) begin
            gs_next = '0;
            ga_next = cfg.wr_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gs_reg        <= '0;
            ga_reg        <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            ga_reg        <= ga_next;
            out_valid_reg <= out_valid_next;
        end
        pend_ok_reg   <= pend_ok_next;
        pend_rd_reg   <= pend_rd_next;
        pend_wr_reg   <= pend_wr_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

[rtl/gap_buffer_text_editor.sv]
// Top level of the gap buffer text editor: length register, controller and store.
`default_nettype none

// Gap buffer text editor. The text lives in a character store of
// buffer_length cells (up to BUF_DEPTH) as two runs with a free gap between
// them; the gap start is the cursor. Each request transfer on the s_ side
// (insert, move left, move right, delete, backspace, read) gives exactly one
// result transfer on the m_ side with the success flag, the character read
// (zero unless a successful read), the text length, the cursor and the gap
// size after the request. The accept cycle issues the one store read (or
// the insert write), the next cycle takes the registered read data,
// writes a carried character back for a cursor move and loads the result
// register. The store has one read and one write port with registered
// read data. A new request is taken at the earliest in the cycle the
// previous result transfers out, so a stalled result holds off the input.
// Writing cfg_wdata with cfg_we reopens the whole store as gap; 0 is taken
// as 1 and values above BUF_DEPTH as BUF_DEPTH. Write it only while no
// request is in flight. No clearing pass: cells are read only after they
// have been written.

`include "gap_buffer_text_editor_assert.svh"

module gap_buffer_text_editor
    import gbte_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,    // buffer_length

    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [23:0]      s_tdata,      // [7:0] char_in, [19:8] read_index, rest 0
    input  wire logic [2:0]       s_tuser,      // [2:0] req_type

    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [47:0]      m_tdata,      // [7:0] char_out, [20:8] text_length,
                                                // [33:21] cursor_position,
                                                // [46:34] gap, [47] 0
    output logic      [0:0]       m_tuser       // [0] ok
);

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  wr_len;
    cfg_t              cfg;
    res_t              res;
    ram_req_t          ram;
    logic [CHAR_W-1:0] ram_rdata;
    logic              span_ok;

    // Clamp the written length into 1..BUF_DEPTH.
    always_comb begin
        priority if (cfg_wdata == '0) begin
            wr_len = LEN_W'(1);
        end else if (cfg_wdata > LEN_MAX) begin
            wr_len = LEN_MAX;
        end else begin
            wr_len = cfg_wdata;
        end
        len_next = cfg_we ? wr_len : len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else begin
            len_reg <= len_next;
        end
    end

    assign cfg.wr     = cfg_we;
    assign cfg.wr_len = wr_len;
    assign cfg.len    = len_reg;

    gbte_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_char   (s_tdata[7:0]),
        .in_idx    (s_tdata[19:8]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .ram       (ram),
        .ram_rdata (ram_rdata)
    );

    gbte_text_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (CHAR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .re    (ram.re),
        .raddr (ram.raddr),
        .rdata (ram_rdata)
    );

    // Result transfer packing.
    assign m_tdata = {1'b0, res.gap, res.cursor, res.text_len, res.ch};
    assign m_tuser = res.ok;

    // Cursor plus gap never runs past the store in use.
    assign span_ok = ({1'b0, res.cursor} + {1'b0, res.gap}) <= {1'b0, len_reg};

    `GBTE_ASSERT(a_span, aclk, aresetn, m_tvalid |-> span_ok, "cursor plus gap beyond length")
    `GBTE_NEVER(a_port_clash, aclk, aresetn, ram.we && ram.re, "store read and write together")
    `GBTE_NEVER(a_hold_in, aclk, aresetn, m_tvalid && !m_tready && s_tready, "taken in stall")
    `GBTE_ASSERT(a_fin_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "taken in finish")

endmodule

`default_nettype wire

[dv/gap_buffer_text_editor_tb.sv]
// Self-checking testbench for the gap buffer text editor: directed edit table, then random edits.
module gap_buffer_text_editor_tb
    import gbte_pkg::*;
();

    // Request kinds outside the enum; the block must answer them with ok = 0 and no change.
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    localparam int CYCLE_LIMIT  = 1000000; // watchdog bound for ~1200 transfers, with margin
    localparam int PARK_CYCLES  = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 4;       // settle time after the last result
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 58;

    // One line of the directed table: either a length write or a request.
    typedef struct {
        bit                 is_cfg;
        logic [LEN_W-1:0]   cfg_val;
        logic [REQ_W-1:0]   kind;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
        bit                 typed;   // want holds a hand-written expectation
        res_t               want;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [LEN_W-1:0]   cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;   // [7:0] char_in, [19:8] read_index, rest 0
    logic [2:0]         s_tuser;   // [2:0] req_type
    logic               m_tvalid;
    logic               m_tready;
    logic [47:0]        m_tdata;   // [7:0] char_out, [20:8] text_length, [33:21] cursor,
                                   // [46:34] gap, [47] 0
    logic [0:0]         m_tuser;   // [0] ok

    // Shadow copy of the editor: store cells, cursor, end of gap, cells in use.
    logic [CHAR_W-1:0]  char_cells [BUF_DEPTH];
    int                 span_len;
    int                 cur_pos;
    int                 tail_head;

    res_t               pending_results [$];
    dir_row_t           dir_tab [$];
    int                 err_count;
    int                 cycles_run;
    bit                 no_gaps;    // burst phase: neither side idles
    bit                 park_req;   // ask the receiver for one long hold-off

    gap_buffer_text_editor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Length write: 0 becomes 1, anything past the store depth is clamped; all cells become gap.
    function automatic void edit_set_length(input logic [LEN_W-1:0] v);
        int n;
        n = int'(v);
        if (n == 0) n = 1;
        if (n > BUF_DEPTH) n = BUF_DEPTH;
        span_len  = n;
        cur_pos   = 0;
        tail_head = n;
    endfunction

    // Applies one request to the shadow buffer and returns the result it should produce.
    function automatic res_t edit_predict(input logic [REQ_W-1:0] kind,
                                          input logic [CHAR_W-1:0] ch,
                                          input logic [IDX_W-1:0] idx);
        res_t r;
        int   free_cells;
        int   phys;
        r = '0;
        case (kind)
            REQ_INSERT: begin
                if (tail_head > cur_pos) begin
                    char_cells[cur_pos] = ch;
                    cur_pos++;
                    r.ok = 1'b1;
                end
            end
            REQ_MOVE_LEFT: begin
                // last char before the cursor hops to just below the gap end
                if (cur_pos > 0) begin
                    char_cells[tail_head-1] = char_cells[cur_pos-1];
                    cur_pos--;
                    tail_head--;
                    r.ok = 1'b1;
                end
            end
            REQ_MOVE_RIGHT: begin
                if (tail_head < span_len) begin
                    char_cells[cur_pos] = char_cells[tail_head];
                    cur_pos++;
                    tail_head++;
                    r.ok = 1'b1;
                end
            end
            REQ_DELETE: begin
                if (tail_head < span_len) begin
                    tail_head++;
                    r.ok = 1'b1;
                end
            end
            REQ_BACKSPACE: begin
                if (cur_pos > 0) begin
                    cur_pos--;
                    r.ok = 1'b1;
                end
            end
            REQ_READ: begin
                // logical index skips over the gap once it passes the cursor
                free_cells = tail_head - cur_pos;
                if (int'(idx) < span_len - free_cells) begin
                    phys = (int'(idx) < cur_pos) ? int'(idx) : int'(idx) + free_cells;
                    if (phys < BUF_DEPTH) begin
                        r.ch = char_cells[phys];
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        free_cells = tail_head - cur_pos;
        r.text_len = LEN_W'(span_len - free_cells);
        r.cursor   = LEN_W'(cur_pos);
        r.gap      = LEN_W'(free_cells);
        return r;
    endfunction

    // Idle stretch length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dir_row_t req_row(input logic [REQ_W-1:0] kind,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] idx);
        dir_row_t row;
        row = '{is_cfg: 1'b0, cfg_val: '0, kind: kind, ch: ch, idx: idx,
                typed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic dir_row_t chk_row(input logic [REQ_W-1:0] kind,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] idx,
                                         input logic ok, input logic [CHAR_W-1:0] rd,
                                         input int tl, input int cur, input int gp);
        dir_row_t row;
        row = req_row(kind, ch, idx);
        row.typed = 1'b1;
        row.want  = '{ok, rd, LEN_W'(tl), LEN_W'(cur), LEN_W'(gp)};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [LEN_W-1:0] v);
        dir_row_t row;
        row = req_row(REQ_INSERT, '0, '0);
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    // One request transfer. Expectation is queued at the accepting edge. With no idle
    // picked, tvalid stays high and the next call just swaps the data at the next negedge.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx, input bit typed, input res_t want);
        res_t model_res;
        int   pause;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {4'b0, idx, ch};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        model_res = edit_predict(kind, ch, idx);
        pending_results.push_back(typed ? want : model_res);
        pause = (no_gaps || $urandom_range(0, 99) >= 40) ? 0 : gap_len();
        if (pause > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (pause - 1) @(negedge aclk);
        end
    endtask

    // Stop offering and wait until every queued result has been taken.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Length register write, only with the editor idle.
    task automatic write_length(input logic [LEN_W-1:0] v);
        drain_results();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        edit_set_length(v);
    endtask

    // Receiver: random stalls, plus one long hold-off on request so the editor backs up.
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (park_req) begin
                m_tready = 1'b0;
                repeat (PARK_CYCLES) @(negedge aclk);
                park_req = 1'b0;
            end else if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
                m_tready = 1'b0;
                hold     = gap_len() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Result checker: every result transfer against the oldest expectation.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[7:0], m_tdata[20:8], m_tdata[33:21], m_tdata[46:34]};
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result transfer: ok=%0d ch=%02h len=%0d cur=%0d gap=%0d",
                             got.ok, got.ch, got.text_len, got.cursor, got.gap);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.ch !== want.ch || got.text_len !== want.text_len ||
                    got.cursor !== want.cursor || got.gap !== want.gap) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"result mismatch: exp ok=%0d ch=%02h len=%0d cur=%0d gap=%0d",
                                  " / got ok=%0d ch=%02h len=%0d cur=%0d gap=%0d"},
                                 want.ok, want.ch, want.text_len, want.cursor, want.gap,
                                 got.ok, got.ch, got.text_len, got.cursor, got.gap);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles_run++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int               p;
        int               n;
        int               pick;
        int               text_now;
        logic [REQ_W-1:0] kind;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len_val;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        err_count = 0;
        no_gaps   = 1'b0;
        park_req  = 1'b0;
        edit_set_length(LEN_RESET);

        // Directed: empty buffer refusals, reserved kinds, char extremes, read past the end,
        // read from the top cell, full store with length 1, clamped length writes.
        dir_tab.push_back(chk_row(REQ_READ,       8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_MOVE_LEFT,  8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_MOVE_RIGHT, 8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_DELETE,     8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_BACKSPACE,  8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_RSVD6,      8'hFF, 12'hFFF, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_RSVD7,      8'hFF, 12'hFFF, 0, 8'h00, 0, 0, 4096));
        dir_tab.push_back(chk_row(REQ_INSERT,     8'hFF, 12'h000, 1, 8'h00, 1, 1, 4095));
        dir_tab.push_back(chk_row(REQ_INSERT,     8'h00, 12'h000, 1, 8'h00, 2, 2, 4094));
        dir_tab.push_back(chk_row(REQ_READ,       8'h00, 12'h000, 1, 8'hFF, 2, 2, 4094));
        dir_tab.push_back(chk_row(REQ_READ,       8'h00, 12'hFFF, 0, 8'h00, 2, 2, 4094));
        dir_tab.push_back(chk_row(REQ_MOVE_LEFT,  8'h00, 12'h000, 1, 8'h00, 2, 1, 4094));
        dir_tab.push_back(req_row(REQ_READ,       8'h00, 12'h001));   // lands in cell 4095
        dir_tab.push_back(req_row(REQ_DELETE,     8'h00, 12'h000));
        dir_tab.push_back(req_row(REQ_MOVE_RIGHT, 8'h00, 12'h000));
        dir_tab.push_back(req_row(REQ_BACKSPACE,  8'h00, 12'h000));
        dir_tab.push_back(cfg_row(LEN_W'(0)));                         // taken as 1
        dir_tab.push_back(chk_row(REQ_INSERT,     8'h5A, 12'h000, 1, 8'h00, 1, 1, 0));
        dir_tab.push_back(chk_row(REQ_INSERT,     8'h3C, 12'h000, 0, 8'h00, 1, 1, 0));
        dir_tab.push_back(chk_row(REQ_MOVE_LEFT,  8'h00, 12'h000, 1, 8'h00, 1, 0, 0));
        dir_tab.push_back(chk_row(REQ_READ,       8'h00, 12'h000, 1, 8'h5A, 1, 0, 0));
        dir_tab.push_back(chk_row(REQ_MOVE_RIGHT, 8'h00, 12'h000, 1, 8'h00, 1, 1, 0));
        dir_tab.push_back(chk_row(REQ_DELETE,     8'h00, 12'h000, 0, 8'h00, 1, 1, 0));
        dir_tab.push_back(chk_row(REQ_BACKSPACE,  8'h00, 12'h000, 1, 8'h00, 0, 0, 1));
        dir_tab.push_back(cfg_row(LEN_W'(8191)));                      // clamped to depth
        dir_tab.push_back(chk_row(REQ_READ,       8'h00, 12'h000, 0, 8'h00, 0, 0, 4096));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg)
                write_length(dir_tab[k].cfg_val);
            else
                send_req(dir_tab[k].kind, dir_tab[k].ch, dir_tab[k].idx,
                         dir_tab[k].typed, dir_tab[k].want);
        end

        // Random phases. Small lengths dominate so full and empty edges come up often;
        // every fourth phase uses an extreme or out-of-range length.
        for (p = 0; p < PHASES; p++) begin
            if (p % 4 == 0) begin
                case (p / 4)
                    0:       len_val = LEN_W'(1);
                    1:       len_val = LEN_W'(4096);
                    2:       len_val = LEN_W'(2);
                    3:       len_val = LEN_W'(0);
                    default: len_val = LEN_W'(5000);
                endcase
            end else if (p % 7 == 5) begin
                len_val = LEN_W'($urandom_range(100, 300));
            end else begin
                len_val = LEN_W'($urandom_range(2, 32));
            end
            write_length(len_val);
            no_gaps = (p % 5 == 2);

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // back-pressure: receiver parks, sender keeps offering
                if (p == 3 && n == 10) park_req = 1'b1;
                // sender stops mid-phase until everything is back
                if (p == 6 && n == 30) drain_results();

                pick     = $urandom_range(0, 99);
                text_now = span_len - (tail_head - cur_pos);
                if (pick < 30)      kind = REQ_INSERT;
                else if (pick < 45) kind = REQ_MOVE_LEFT;
                else if (pick < 60) kind = REQ_MOVE_RIGHT;
                else if (pick < 70) kind = REQ_DELETE;
                else if (pick < 80) kind = REQ_BACKSPACE;
                else if (pick < 97) kind = REQ_READ;
                else                kind = pick[0] ? REQ_RSVD7 : REQ_RSVD6;

                // reads mostly near the text, some anywhere in the index range
                if ($urandom_range(0, 3) != 0)
                    idx = IDX_W'($urandom_range(0, text_now));
                else
                    idx = IDX_W'($urandom_range(0, 4095));

                send_req(kind, CHAR_W'($urandom_range(0, 255)), idx, 1'b0, '0);
            end
        end

        drain_results();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
